// ----- hdl/adc_pkg.sv -----
// Shared constants for the allpass dispersion cascade.
`default_nettype none

package adc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned StageCountDef = 4;
  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned CoefBitsDef   = 16;

  // State and inter-stage values carry two guard bits
  localparam int unsigned GuardBits = 2;

  // Configuration register map
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned RegCoefs    = 4;
  localparam int unsigned CoefIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegFlushLevel = 3'd4;
  localparam int unsigned FlushBits   = 8;

  // Cell phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMul1 = 2'd1;
  localparam logic [1:0] PhSum  = 2'd2;
  localparam logic [1:0] PhMul2 = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/adc_ifs.sv -----
// Valid/ready stream interfaces for the input and output sample channels.
`default_nettype none

interface adc_in_if #(
  parameter int unsigned W = adc_pkg::SampleBitsDef
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface adc_out_if #(
  parameter int unsigned W = adc_pkg::SampleBitsDef
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- hdl/adc_cell.sv -----
// One first-order allpass section: y = a*x + s, then s = x - a*y.
`default_nettype none

module adc_cell #(
  parameter int unsigned SW = adc_pkg::SampleBitsDef + adc_pkg::GuardBits,
  parameter int unsigned CB = adc_pkg::CoefBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic signed [CB-1:0]               coef_i,
  input  wire logic        [adc_pkg::FlushBits-1:0] flush_i,
  input  wire logic                               go_i,
  input  wire logic signed [SW-1:0]               x_i,
  output logic                                    go_o,
  output logic signed [SW-1:0]                    y_o,
  output logic                                    done_o
);

  localparam int unsigned PW = SW + CB;
  localparam int unsigned CF = CB - 1;
  localparam int unsigned EW = SW + 2;

  logic [1:0]            ph_q, ph_d;
  logic signed [SW-1:0]  x_q, y_q, s_q;
  logic signed [PW-1:0]  prod_q;

  logic signed [SW-1:0]  mul_src;
  logic signed [PW-1:0]  mul, prod_rnd;
  logic signed [SW:0]    rnd;
  logic signed [EW-1:0]  sum, diff;
  logic signed [SW-1:0]  sum_sat, diff_sat, s_new;
  logic        [SW:0]    diff_mag;

  // One shared multiplier: a*x in the first phase, a*y in the third
  assign mul_src  = (ph_q == adc_pkg::PhSum) ? y_q : x_i;
  assign mul      = PW'(coef_i) * PW'(mul_src);

  // Round half up to the sample LSB
  assign prod_rnd = prod_q + (PW'(1) <<< (CF - 1));
  assign rnd      = $signed(prod_rnd[PW-1:CF]);

  assign sum  = EW'(rnd) + EW'(s_q);
  assign diff = EW'(x_q) - EW'(rnd);

  always_comb begin
    if (sum[EW-1:SW-1] == '0 || sum[EW-1:SW-1] == '1) begin
      sum_sat = sum[SW-1:0];
    end else if (sum[EW-1]) begin
      sum_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_comb begin
    if (diff[EW-1:SW-1] == '0 || diff[EW-1:SW-1] == '1) begin
      diff_sat = diff[SW-1:0];
    end else if (diff[EW-1]) begin
      diff_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      diff_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Small-magnitude flush of the stored state
  assign diff_mag = diff_sat[SW-1] ? (SW+1)'(-(EW'(diff_sat))) : (SW+1)'(diff_sat);
  assign s_new    = (diff_mag <= (SW+1)'(flush_i)) ? '0 : diff_sat;

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      adc_pkg::PhIdle: if (go_i) ph_d = adc_pkg::PhMul1;
      adc_pkg::PhMul1: ph_d = adc_pkg::PhSum;
      adc_pkg::PhSum:  ph_d = adc_pkg::PhMul2;
      adc_pkg::PhMul2: ph_d = adc_pkg::PhIdle;
      default:         ph_d = adc_pkg::PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= adc_pkg::PhIdle;
      s_q  <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == adc_pkg::PhMul2) begin
        s_q <= s_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == adc_pkg::PhIdle && go_i) begin
      x_q    <= x_i;
      prod_q <= mul;
    end
    if (ph_q == adc_pkg::PhMul1) begin
      y_q <= sum_sat;
    end
    if (ph_q == adc_pkg::PhSum) begin
      prod_q <= mul;
    end
  end

  // y is handed on while the second product is formed
  assign go_o   = (ph_q == adc_pkg::PhSum);
  assign y_o    = y_q;
  assign done_o = (ph_q == adc_pkg::PhMul2);

endmodule

`default_nettype wire

// ----- hdl/allpass_dispersion_cascade.sv -----
// Top level: register file, chain of allpass cells, output register with skid.
//
//   channel   dir   payload               request moves when
//   in_i      in    sample_in  (Q1.23)    in_i.valid & in_i.ready
//   out_o     out   sample_out (Q1.23)    out_o.valid & out_o.ready
//   cfg       in    cfg_idx_i, cfg_data_i cfg_we_i
//
// One sample is in the chain at a time; each cell does two multiplies on one
// shared multiplier and hands y on between them, so the result is registered
// when the last cell hands its y on, and the next request is taken once that
// cell has stored its state and the skid stage is empty.
// A waiting result sits in the output register, one more parks in the skid
// stage, then input stalls. Reset clears coefficients, flush level, memories.
`default_nettype none

module allpass_dispersion_cascade #(
  parameter int unsigned STAGE_COUNT = adc_pkg::StageCountDef,
  parameter int unsigned SAMPLE_BITS = adc_pkg::SampleBitsDef,
  parameter int unsigned COEF_BITS   = adc_pkg::CoefBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  adc_in_if.sink                              in_i,
  adc_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [adc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [COEF_BITS-1:0]           cfg_data_i
);

  localparam int unsigned SW = SAMPLE_BITS + adc_pkg::GuardBits;
  localparam int unsigned SB = SAMPLE_BITS;

  logic signed [COEF_BITS-1:0]         coef_q [adc_pkg::RegCoefs];
  logic        [adc_pkg::FlushBits-1:0] flush_q;

  logic busy_q;
  logic out_v_q, skid_v_q;
  logic signed [SB-1:0] out_q, skid_q;

  logic                 go   [STAGE_COUNT+1];
  logic signed [SW-1:0] y    [STAGE_COUNT+1];
  logic                 done [STAGE_COUNT];

  logic                 accept, taken;
  logic signed [SB-1:0] res_sat, res;
  logic        [SB:0]   res_mag;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < adc_pkg::RegCoefs; k++) begin
        coef_q[k] <= '0;
      end
      flush_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < adc_pkg::CfgIdxBits'(adc_pkg::RegCoefs)) begin
        coef_q[cfg_idx_i[adc_pkg::CoefIdxBits-1:0]] <= cfg_data_i;
      end else if (cfg_idx_i == adc_pkg::RegFlushLevel) begin
        flush_q <= cfg_data_i[adc_pkg::FlushBits-1:0];
      end
    end
  end

  assign in_i.ready = !busy_q && !skid_v_q;
  assign accept     = in_i.valid && in_i.ready;

  assign go[0] = accept;
  assign y[0]  = SW'(in_i.sample_in);

  for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_cell
    logic signed [COEF_BITS-1:0] coef;
    if (k < adc_pkg::RegCoefs) begin : g_reg
      assign coef = coef_q[k];
    end else begin : g_delay
      // stages without a register act as a one-sample delay
      assign coef = '0;
    end

    adc_cell #(
      .SW (SW),
      .CB (COEF_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (coef),
      .flush_i (flush_q),
      .go_i    (go[k]),
      .x_i     (y[k]),
      .go_o    (go[k+1]),
      .y_o     (y[k+1]),
      .done_o  (done[k])
    );
  end

  // Saturate to the sample width, then flush small magnitudes
  always_comb begin
    if (y[STAGE_COUNT][SW-1:SB-1] == '0 || y[STAGE_COUNT][SW-1:SB-1] == '1) begin
      res_sat = y[STAGE_COUNT][SB-1:0];
    end else if (y[STAGE_COUNT][SW-1]) begin
      res_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  assign res_mag = res_sat[SB-1] ? (SB+1)'(-((SB+1)'(res_sat))) : (SB+1)'(res_sat);
  assign res     = (res_mag <= (SB+1)'(flush_q)) ? '0 : res_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done[STAGE_COUNT-1]) begin
      busy_q <= 1'b0;
    end
  end

  assign taken = out_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (go[STAGE_COUNT]) begin
      if (!out_v_q || taken) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (taken) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[STAGE_COUNT]) begin
      if (!out_v_q || taken) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (taken && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.sample_out = out_q;

endmodule

`default_nettype wire

// ----- verif/allpass_dispersion_cascade_test.sv -----
// Self-checking testbench for the four-stage allpass dispersion cascade.
`default_nettype none

module allpass_dispersion_cascade_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGE_COUNT = adc_pkg::StageCountDef;
  localparam int unsigned SAMPLE_BITS = adc_pkg::SampleBitsDef;
  localparam int unsigned COEF_BITS   = adc_pkg::CoefBitsDef;
  localparam int unsigned STATE_BITS  = SAMPLE_BITS + adc_pkg::GuardBits;
  localparam int unsigned IDX_BITS    = adc_pkg::CfgIdxBits;

  localparam logic [IDX_BITS-1:0] RegCoef0   = 3'd0;
  localparam logic [IDX_BITS-1:0] RegCoef1   = 3'd1;
  localparam logic [IDX_BITS-1:0] RegCoef2   = 3'd2;
  localparam logic [IDX_BITS-1:0] RegCoef3   = 3'd3;
  localparam logic [IDX_BITS-1:0] RegSpare5  = 3'd5;
  localparam logic [IDX_BITS-1:0] RegSpare6  = 3'd6;
  localparam logic [IDX_BITS-1:0] RegSpare7  = 3'd7;

  localparam logic [COEF_BITS-1:0] CoefPosLim = 16'h7333;  // +0.9
  localparam logic [COEF_BITS-1:0] CoefNegLim = 16'h8CCD;  // -0.9
  localparam logic [COEF_BITS-1:0] CoefMax    = 16'h7FFF;
  localparam logic [COEF_BITS-1:0] CoefMin    = 16'h8000;

  localparam int SMP_MAX = 8388607;
  localparam int SMP_MIN = -8388608;

  localparam int DRAIN_CYCLES   = 2 * STAGE_COUNT + 4;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 125;
  localparam int HOLD_CYCLES    = 120;
  localparam int REPORT_LIMIT   = 10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef enum bit {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [IDX_BITS-1:0]   idx;
    logic [COEF_BITS-1:0]  data;
    sample_t               smp;
    bit                    typed;
    sample_t               want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [IDX_BITS-1:0]  cfg_idx;
  logic [COEF_BITS-1:0] cfg_data;

  adc_in_if  #(.W(SAMPLE_BITS)) in_ch ();
  adc_out_if #(.W(SAMPLE_BITS)) out_ch ();

  allpass_dispersion_cascade #(
    .STAGE_COUNT(STAGE_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Cascade predictor state
  longint               stage_mem [STAGE_COUNT];
  logic signed [15:0]   coef_reg  [STAGE_COUNT];
  logic [7:0]           flush_lvl;

  sample_t   expected_samples[$];
  stim_row_t directed_rows[$];
  int        mismatches;
  int        cycle_cnt;
  int        hold_cycles;
  int        stall_left;
  bit        idle_on;

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q1.15 times value, rounded half up to the value's scale
  function automatic longint mul_q15(longint a, longint v);
    return (a * v + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
  endfunction

  function automatic longint squash(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    return (mag <= longint'(flush_lvl)) ? 0 : v;
  endfunction

  function automatic sample_t cascade_step(sample_t smp);
    longint x;
    longint y;
    x = longint'(smp);
    y = 0;
    for (int k = 0; k < STAGE_COUNT; k++) begin
      y = clip(mul_q15(longint'(coef_reg[k]), x) + stage_mem[k], STATE_BITS);
      stage_mem[k] = clip(x - mul_q15(longint'(coef_reg[k]), y), STATE_BITS);
      x = y;
    end
    for (int k = 0; k < STAGE_COUNT; k++) stage_mem[k] = squash(stage_mem[k]);
    y = squash(clip(x, SAMPLE_BITS));
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic void apply_reg(logic [IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    if (idx < adc_pkg::RegCoefs) begin
      coef_reg[idx] = data;
    end else if (idx == adc_pkg::RegFlushLevel) begin
      flush_lvl = data[7:0];
    end
  endfunction

  function automatic void flag_error(string what, sample_t want, sample_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function automatic void add_sample(int v, bit typed = 1'b0, int want = 0);
    stim_row_t r;
    r.kind  = RowSample;
    r.idx   = '0;
    r.data  = '0;
    r.smp   = v[SAMPLE_BITS-1:0];
    r.typed = typed;
    r.want  = want[SAMPLE_BITS-1:0];
    directed_rows.push_back(r);
  endfunction

  function automatic void add_write(logic [IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    stim_row_t r;
    r.kind  = RowWrite;
    r.idx   = idx;
    r.data  = data;
    r.smp   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_coef();
    int c;
    case ($urandom_range(0, 7))
      0: return COEF_BITS'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return CoefPosLim;
          1: return CoefNegLim;
          2: return CoefMax;
          3: return CoefMin;
          default: return '0;
        endcase
      end
      default: begin
        c = int'($urandom_range(0, 58982)) - 29491;
        return c[COEF_BITS-1:0];
      end
    endcase
  endfunction

  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom);
      4, 5: v = int'($urandom_range(0, 2 * (flush_lvl + 40))) - (flush_lvl + 40);
      6: v = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
      default: v = int'($urandom_range(0, 2097152)) - 1048576;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Register writes only with the chain empty
  task automatic cfg_write(logic [IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_sample(sample_t v, bit typed, sample_t want);
    sample_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= v;
    do @(posedge clk); while (!in_ch.ready);
    pred = cascade_step(v);
    expected_samples.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        flag_error("unexpected output", '0, out_ch.sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample_out !== want) flag_error("sample_out mismatch", want, out_ch.sample_out);
      end
    end
  end

  initial begin
    for (int k = 0; k < STAGE_COUNT; k++) begin
      stage_mem[k] = 0;
      coef_reg[k]  = '0;
    end
    flush_lvl       = '0;
    mismatches      = 0;
    cycle_cnt       = 0;
    hold_cycles     = 0;
    idle_on         = 1'b1;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;

    // Zero coefficients after reset: four-sample delay line
    add_sample(SMP_MAX, 1'b1, 0);
    add_sample(SMP_MIN, 1'b1, 0);
    add_sample(1, 1'b1, 0);
    add_sample(-1, 1'b1, 0);
    add_sample(100, 1'b1, SMP_MAX);
    add_sample(-100, 1'b1, SMP_MIN);
    add_sample(0, 1'b1, 1);
    add_sample(4660, 1'b1, -1);
    // Largest flush level; writes past the register map are dropped
    add_write(adc_pkg::RegFlushLevel, 16'h00FF);
    add_write(RegSpare5, 16'hFFFF);
    add_write(RegSpare7, 16'h7FFF);
    add_sample(200);
    add_sample(-255);
    add_sample(256);
    add_sample(-256);
    // Limits and out-of-range coefficients, full-scale input to hit saturation
    add_write(RegCoef0, CoefPosLim);
    add_write(RegCoef1, CoefNegLim);
    add_write(RegCoef2, CoefMax);
    add_write(RegCoef3, CoefMin);
    add_write(adc_pkg::RegFlushLevel, 16'hFF00);
    add_sample(SMP_MAX);
    add_sample(SMP_MAX);
    add_sample(SMP_MIN);
    add_sample(SMP_MIN);
    add_sample(SMP_MAX);
    add_sample(0);
    add_sample(-1);
    add_sample(1);
    add_write(RegCoef0, CoefMin);
    add_write(RegCoef1, CoefMin);
    add_write(RegCoef2, CoefMax);
    add_write(RegCoef3, CoefMax);
    add_write(adc_pkg::RegFlushLevel, 16'h0001);
    add_sample(SMP_MIN);
    add_sample(SMP_MAX);
    add_sample(1);
    add_sample(-2);
    add_sample(0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite)
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      else
        push_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph != 5) && (ph != NUM_PHASES - 1);
      if (ph == 7) begin
        // back to plain delay stages
        cfg_write(RegCoef0, '0);
        cfg_write(RegCoef1, '0);
        cfg_write(RegCoef2, '0);
        cfg_write(RegCoef3, '0);
      end else begin
        cfg_write(RegCoef0, pick_coef());
        if (ph == 0 || $urandom_range(0, 3) != 0) cfg_write(RegCoef1, pick_coef());
        if (ph == 0 || $urandom_range(0, 3) != 0) cfg_write(RegCoef2, pick_coef());
        if (ph == 0 || $urandom_range(0, 3) != 0) cfg_write(RegCoef3, pick_coef());
      end
      case ($urandom_range(0, 3))
        0: cfg_write(adc_pkg::RegFlushLevel, {8'($urandom), 8'h00});
        1: cfg_write(adc_pkg::RegFlushLevel, {8'($urandom), 8'hFF});
        default: cfg_write(adc_pkg::RegFlushLevel, 16'($urandom));
      endcase
      if ($urandom_range(0, 2) == 0)
        cfg_write($urandom_range(0, 1) ? RegSpare6 : RegSpare5, 16'($urandom));
      // long output hold-off so the chain backs up into the input
      if (ph == 2) hold_cycles = HOLD_CYCLES;
      repeat (PHASE_ITEMS) push_sample(pick_sample(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_samples.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
